// ----- sv/escaped_text_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// escaped_text_decoder_defines.svh
// Assertion macros used by the escaped text decoder checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_TEXT_DECODER_DEFINES_SVH
`define ESCAPED_TEXT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ESCD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escaped_text_decoder: assertion failed");

// Next-cycle implication, disabled during reset
`define ESCD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escaped_text_decoder: assertion failed");

`endif

// ----- sv/escd_pkg.sv -----
// ----------------------------------------------------------------------------
// escd_pkg
// Types and character constants of the escaped text decoder.
// ----------------------------------------------------------------------------
package escd_pkg;

   // Characters recognised by the decoder
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_E         = 8'h65;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;

   // Bytes the escapes stand for
   localparam logic [7:0] CODE_ESC = 8'h1B;
   localparam logic [7:0] CODE_LF  = 8'h0A;
   localparam logic [7:0] CODE_CR  = 8'h0D;
   localparam logic [7:0] CODE_TAB = 8'h09;

   localparam int unsigned LEN_W = 13;

   // One request item
   typedef struct packed {
      logic       last_byte;
      logic [7:0] text_byte;
   } item_type;

   // One result item
   typedef struct packed {
      logic [LEN_W-1:0] decoded_length;
      logic             escape_error;
      logic             text_done;
      logic             byte_valid;
      logic [7:0]       decoded_byte;
   } result_type;

endpackage

// ----- sv/escd_in_reg.sv -----
// ----------------------------------------------------------------------------
// escd_in_reg
// Input register: holds one request and releases it to the decode stage.
// ----------------------------------------------------------------------------
module escd_in_reg
   import escd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     s_valid,
   output logic     s_ready,
   input  item_type s_item,
   output logic     m_valid,
   input  logic     m_ready,
   output item_type m_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // Free when empty or when the held request moves on this cycle
   assign s_ready = !valid_ff || m_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (s_ready) begin
         valid_in = s_valid;
         item_in  = s_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign m_valid = valid_ff;
   assign m_item  = item_ff;

endmodule

// ----- sv/escd_decode.sv -----
// ----------------------------------------------------------------------------
// escd_decode
// Escape decoding state, byte count and the result register.
// ----------------------------------------------------------------------------
module escd_decode
   import escd_pkg::*;
#(
   parameter int unsigned MAX_TEXT_LEN = 4096
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam int unsigned CNT_W = $clog2(MAX_TEXT_LEN + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT_LEN);

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX_H = 2'd2,
      MODE_HEX_L = 2'd3
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [3:0]       nib_ff, nib_in;
   logic             err_ff, err_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   result_type       rsp_ff, rsp_in;

   logic             adv;
   logic             is_hex;
   logic [3:0]       hex_val;
   logic             out_vld;
   logic [7:0]       out_byte;
   logic             err_now;
   logic [CNT_W-1:0] cnt_next;
   logic             err_final;
   logic [CNT_W+LEN_W-1:0] cnt_ext;

   // Result register is free when empty or being taken
   assign adv      = !valid_ff || rsp_ready;
   assign in_ready = adv;

   // Hex digit detection, either case
   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      unique if (in_item.text_byte >= 8'h30 && in_item.text_byte <= 8'h39) begin
         hex_val = 4'(in_item.text_byte - 8'h30);
      end else if (in_item.text_byte >= 8'h61 && in_item.text_byte <= 8'h66) begin
         hex_val = 4'(in_item.text_byte - 8'h57);
      end else if (in_item.text_byte >= 8'h41 && in_item.text_byte <= 8'h46) begin
         hex_val = 4'(in_item.text_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   // Mode step for the current byte
   always_comb begin
      mode_in  = mode_ff;
      nib_in   = nib_ff;
      out_vld  = 1'b0;
      out_byte = 8'h00;
      err_now  = 1'b0;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (in_item.text_byte == CHAR_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               out_vld  = 1'b1;
               out_byte = in_item.text_byte;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            out_vld = 1'b1;
            unique case (in_item.text_byte)
               CHAR_X: begin
                  mode_in = MODE_HEX_H;
                  out_vld = 1'b0;
               end
               CHAR_BACKSLASH: out_byte = CHAR_BACKSLASH;
               CHAR_QUOTE:     out_byte = CHAR_QUOTE;
               CHAR_E:         out_byte = CODE_ESC;
               CHAR_N:         out_byte = CODE_LF;
               CHAR_R:         out_byte = CODE_CR;
               CHAR_T:         out_byte = CODE_TAB;
               default: begin
                  out_vld = 1'b0;
                  err_now = 1'b1;
               end
            endcase
         end
         MODE_HEX_H: begin
            if (is_hex) begin
               nib_in  = hex_val;
               mode_in = MODE_HEX_L;
            end else begin
               err_now = 1'b1;
               mode_in = MODE_PLAIN;
            end
         end
         MODE_HEX_L: begin
            mode_in = MODE_PLAIN;
            if (is_hex) begin
               out_vld  = 1'b1;
               out_byte = {nib_ff, hex_val};
            end else begin
               err_now = 1'b1;
            end
         end
         default: mode_in = MODE_PLAIN;
      endcase
   end

   // Saturating count and sticky error, including an escape cut short
   assign cnt_next  = (out_vld && cnt_ff < MAX_CNT) ? cnt_ff + 1'b1 : cnt_ff;
   assign err_final = err_ff || err_now || (in_item.last_byte && mode_in != MODE_PLAIN);
   assign cnt_ext   = {{LEN_W{1'b0}}, cnt_next};

   // Next values of state and result register
   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      if (adv) begin
         valid_in = in_valid;
      end
      if (adv && in_valid) begin
         rsp_in.decoded_byte   = out_byte;
         rsp_in.byte_valid     = out_vld;
         rsp_in.text_done      = in_item.last_byte;
         rsp_in.escape_error   = in_item.last_byte && err_final;
         rsp_in.decoded_length = cnt_ext[LEN_W-1:0];
         err_in = in_item.last_byte ? 1'b0 : err_final;
         cnt_in = in_item.last_byte ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         nib_ff   <= 4'd0;
         err_ff   <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (adv && in_valid) begin
            mode_ff <= in_item.last_byte ? MODE_PLAIN : mode_in;
            nib_ff  <= in_item.last_byte ? 4'd0 : nib_in;
         end
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- sv/escaped_text_decoder.sv -----
// ----------------------------------------------------------------------------
// escaped_text_decoder
// Decodes backslash-escaped text one byte per request.
// ----------------------------------------------------------------------------
// Request channel (req_*): one escaped byte per request in req_tdata, with
// req_tlast on the final byte of a text. Result channel (rsp_*): exactly one
// result per request, in order. rsp_tuser says whether a decoded byte is
// present; rsp_tlast marks the result of the final byte, which also carries
// the malformed-escape flag and the final decoded length.
// Escapes: \" \\ \e \n \r \t and \xHH (either case); other bytes pass.
// A request passes through the input register, then the result register,
// before its result is offered on rsp_tvalid. Throughput: one request per
// cycle while rsp_tready is high, set by the single decode step between
// the two registers.
// Reset (synchronous, active high) empties both registers and returns the
// decoder to plain text with a zero count and no error.
// When the receiver holds rsp_tready low the result holds, the input
// register takes one more request if it is empty, and req_tready then drops.
// ----------------------------------------------------------------------------
module escaped_text_decoder
   import escd_pkg::*;
#(
   parameter int unsigned MAX_TEXT_LEN = 4096
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] decoded_byte, [8] escape_error,
                                    // [21:9] decoded_length, [23:22] zero
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // text_done
);

   item_type   req_item;
   item_type   dec_item;
   logic       dec_valid;
   logic       dec_ready;
   result_type rsp;

   assign req_item.text_byte = req_tdata;
   assign req_item.last_byte = req_tlast;

   escd_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .s_valid (req_tvalid),
      .s_ready (req_tready),
      .s_item  (req_item),
      .m_valid (dec_valid),
      .m_ready (dec_ready),
      .m_item  (dec_item)
   );

   escd_decode #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_item   (dec_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Result packing
   assign rsp_tdata = {2'b00, rsp.decoded_length, rsp.escape_error, rsp.decoded_byte};
   assign rsp_tuser = rsp.byte_valid;
   assign rsp_tlast = rsp.text_done;

endmodule

// ----- sv/escd_checker.sv -----
// ----------------------------------------------------------------------------
// escd_checker
// Port-level checks on the result channel of the escaped text decoder.
// ----------------------------------------------------------------------------
`include "escaped_text_decoder_defines.svh"

module escd_checker #(
   parameter int unsigned MAX_TEXT_LEN = 4096
)(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result holds
   `ESCD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // No decoded byte means a zero byte field
   `ESCD_ASSERT_IMP(a_empty_byte, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[7:0] == 8'h00)

   // Error flag only reported at the end of a text
   `ESCD_ASSERT_IMP(a_err_on_last, clock, reset, rsp_tvalid && !rsp_tlast, !rsp_tdata[8])

   // Length never exceeds the saturation limit
   `ESCD_ASSERT_IMP(a_len_sat, clock, reset, rsp_tvalid, (MAX_TEXT_LEN >= 8192) || (rsp_tdata[21:9] <= MAX_TEXT_LEN))

endmodule

bind escaped_text_decoder escd_checker #(
   .MAX_TEXT_LEN (MAX_TEXT_LEN)
) u_escd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escaped text decoder. A short table of
// directed requests covers the byte extremes, every escape, bad letters and
// digits and text ending inside an escape. It is followed by random texts,
// mostly well formed with random content. Every result is checked against
// a behavioural decoder held in the bench, or against a typed-in expectation.
// ----------------------------------------------------------------------------
module tb
   import escd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_TEXT_LEN   = 4096;
   localparam int          RANDOM_ITEMS   = 400;
   localparam int          CALM_ITEMS     = 60;     // tail of the run with no idling
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          DIRECTED_ROWS  = 25;

   // Hex digit characters
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_LC_A = 8'h61;
   localparam logic [7:0] CHAR_LC_F = 8'h66;
   localparam logic [7:0] CHAR_UC_A = 8'h41;
   localparam logic [7:0] CHAR_UC_F = 8'h46;
   localparam logic [4:0] NOT_HEX   = 5'd16;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_ESCAPE,
      MODE_HEX_HIGH,
      MODE_HEX_LOW
   } esc_mode_type;

   // One directed request, with an optional typed-in expectation
   typedef struct packed {
      logic [7:0]       text_byte;
      logic             last_byte;
      logic             typed;
      logic [7:0]       exp_byte;
      logic             exp_valid;
      logic             exp_done;
      logic             exp_bad;
      logic [LEN_W-1:0] exp_len;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] text_byte
   logic        req_tlast = 1'b0;     // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [7:0] decoded_byte, [8] escape_error,
                                      // [21:9] decoded_length, [23:22] zero
   logic        rsp_tuser;            // byte_valid
   logic        rsp_tlast;            // text_done

   // Decoder state of the bench's own model
   esc_mode_type     esc_mode  = MODE_PLAIN;
   logic [3:0]       hex_high  = 4'h0;
   logic             malformed = 1'b0;
   logic [LEN_W-1:0] out_count = '0;

   result_type awaited_results [$];
   item_type   text_q [$];

   int  error_count  = 0;
   int  stall_cycles = 0;
   int  rx_hold      = 0;
   bit  tx_gaps      = 1'b1;
   bit  rx_stalls    = 1'b1;

   // Directed table; only rows whose result is obvious carry one
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // after reset: lowest byte passes, length one
      '{8'h00,          1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 13'd1},
      '{8'hFF,          1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_N,         1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_QUOTE,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_E,         1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_R,         1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_T,         1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_X,         1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_LC_A,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_UC_F,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      // high byte as an escape letter is malformed
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{8'h80,          1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      // bad high hex digit on the final byte
      '{CHAR_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{CHAR_X,         1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      '{8'h47,          1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 13'd0},
      // fresh text ending inside an escape
      '{CHAR_BACKSLASH, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 13'd0},
      // one-byte text of the top byte
      '{8'hFF,          1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 13'd1}
   };

   escaped_text_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Digit value, or NOT_HEX for anything else
   function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return {1'b0, c[3:0]};
      if (c >= CHAR_LC_A && c <= CHAR_LC_F) return 5'(c - CHAR_LC_A + 8'd10);
      if (c >= CHAR_UC_A && c <= CHAR_UC_F) return 5'(c - CHAR_UC_A + 8'd10);
      return NOT_HEX;
   endfunction

   // Advance the model by one request and return the decoded result
   function automatic result_type decode_escaped_byte(input item_type it);
      result_type r;
      logic [4:0] d;
      r = '0;
      unique case (esc_mode)
         MODE_PLAIN: begin
            if (it.text_byte == CHAR_BACKSLASH) begin
               esc_mode = MODE_ESCAPE;
            end else begin
               r.byte_valid   = 1'b1;
               r.decoded_byte = it.text_byte;
            end
         end
         MODE_ESCAPE: begin
            esc_mode = MODE_PLAIN;
            r.byte_valid = 1'b1;
            unique case (it.text_byte)
               CHAR_X: begin
                  esc_mode     = MODE_HEX_HIGH;
                  r.byte_valid = 1'b0;
               end
               CHAR_BACKSLASH, CHAR_QUOTE: r.decoded_byte = it.text_byte;
               CHAR_E: r.decoded_byte = CODE_ESC;
               CHAR_N: r.decoded_byte = CODE_LF;
               CHAR_R: r.decoded_byte = CODE_CR;
               CHAR_T: r.decoded_byte = CODE_TAB;
               default: begin
                  r.byte_valid = 1'b0;
                  malformed    = 1'b1;
               end
            endcase
         end
         MODE_HEX_HIGH: begin
            d = hex_digit_value(it.text_byte);
            if (d != NOT_HEX) begin
               hex_high = d[3:0];
               esc_mode = MODE_HEX_LOW;
            end else begin
               malformed = 1'b1;
               esc_mode  = MODE_PLAIN;
            end
         end
         MODE_HEX_LOW: begin
            d = hex_digit_value(it.text_byte);
            if (d != NOT_HEX) begin
               r.byte_valid   = 1'b1;
               r.decoded_byte = {hex_high, d[3:0]};
            end else begin
               malformed = 1'b1;
            end
            esc_mode = MODE_PLAIN;
         end
      endcase

      // length saturates
      if (r.byte_valid && out_count < LEN_W'(MAX_TEXT_LEN)) out_count = out_count + 1'b1;
      // text cut off inside an escape
      if (it.last_byte && esc_mode != MODE_PLAIN) malformed = 1'b1;

      r.text_done      = it.last_byte;
      r.escape_error   = it.last_byte & malformed;
      r.decoded_length = out_count;

      if (it.last_byte) begin
         esc_mode  = MODE_PLAIN;
         hex_high  = 4'h0;
         malformed = 1'b0;
         out_count = '0;
      end
      return r;
   endfunction

   // Present one request; on acceptance record what should come back
   task automatic send_request(input item_type it, input bit typed,
                               input result_type typed_res);
      result_type predicted;
      int gap;
      @(negedge clock);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = it.text_byte;
      req_tlast  = it.last_byte;
      do @(posedge clock); while (!req_tready);
      predicted = decode_escaped_byte(it);
      awaited_results.push_back(typed ? typed_res : predicted);
   endtask

   function automatic void push_text_byte(input logic [7:0] b);
      text_q.push_back(item_type'{last_byte: 1'b0, text_byte: b});
   endfunction

   function automatic logic [7:0] random_plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CHAR_BACKSLASH) ? ~b : b;
   endfunction

   function automatic logic [7:0] random_hex_char();
      logic [7:0] v;
      v = 8'($urandom_range(0, 15));
      if (v < 8'd10) return CHAR_0 + v;
      return ($urandom_range(0, 1) ? CHAR_LC_A : CHAR_UC_A) + v - 8'd10;
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (hex_digit_value(b) != NOT_HEX);
      return b;
   endfunction

   // One random text: mostly valid pieces, some malformed ones and noise
   function automatic void build_random_text();
      int pieces;
      int kind;
      logic [7:0] b;
      logic [7:0] simple_letters [6];
      simple_letters = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_E, CHAR_N, CHAR_R, CHAR_T};
      pieces = $urandom_range(1, 10);
      for (int p = 0; p < pieces; p++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            push_text_byte(random_plain_byte());
         end else if (kind < 65) begin
            push_text_byte(CHAR_BACKSLASH);
            push_text_byte(simple_letters[$urandom_range(0, 5)]);
         end else if (kind < 85) begin
            push_text_byte(CHAR_BACKSLASH);
            push_text_byte(CHAR_X);
            push_text_byte(random_hex_char());
            push_text_byte(random_hex_char());
         end else if (kind < 91) begin
            // unknown escape letter
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_X || b == CHAR_BACKSLASH || b == CHAR_QUOTE || b == CHAR_E ||
                   b == CHAR_N || b == CHAR_R || b == CHAR_T);
            push_text_byte(CHAR_BACKSLASH);
            push_text_byte(b);
         end else if (kind < 96) begin
            // bad high or bad low digit
            push_text_byte(CHAR_BACKSLASH);
            push_text_byte(CHAR_X);
            if ($urandom_range(0, 1)) push_text_byte(random_hex_char());
            push_text_byte(random_non_hex());
         end else begin
            push_text_byte(8'($urandom_range(0, 255)));
         end
      end
      // sometimes cut the text off inside an escape
      kind = $urandom_range(0, 99);
      if (kind < 9) begin
         push_text_byte(CHAR_BACKSLASH);
         if (kind >= 3) push_text_byte(CHAR_X);
         if (kind >= 6) push_text_byte(random_hex_char());
      end
      text_q[text_q.size() - 1].last_byte = 1'b1;
   endfunction

   // Receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (!rx_stalls) rx_hold = 0;
      if (rx_hold == 0 && rx_stalls && $urandom_range(0, 5) == 0)
         rx_hold = $urandom_range(1, 18);
      if (rx_hold != 0) begin
         rsp_tready = 1'b0;
         rx_hold--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   function automatic bit field_differs(input string name, input int unsigned want,
                                        input int unsigned got, input bit bad);
      if (bad) $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return bad;
   endfunction

   // Result checking against the oldest expectation
   always @(posedge clock) begin
      result_type got;
      result_type want;
      bit         bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.decoded_byte   = rsp_tdata[7:0];
         got.escape_error   = rsp_tdata[8];
         got.decoded_length = rsp_tdata[21:9];
         got.byte_valid     = rsp_tuser;
         got.text_done      = rsp_tlast;
         if (awaited_results.size() == 0) begin
            $display("%0t: result with nothing expected: expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            bad = 1'b0;
            bad |= field_differs("decoded_byte", 32'(want.decoded_byte),
                                 32'(got.decoded_byte),
                                 want.decoded_byte !== got.decoded_byte);
            bad |= field_differs("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid),
                                 want.byte_valid !== got.byte_valid);
            bad |= field_differs("text_done", 32'(want.text_done), 32'(got.text_done),
                                 want.text_done !== got.text_done);
            bad |= field_differs("escape_error", 32'(want.escape_error),
                                 32'(got.escape_error),
                                 want.escape_error !== got.escape_error);
            bad |= field_differs("decoded_length", 32'(want.decoded_length),
                                 32'(got.decoded_length),
                                 want.decoded_length !== got.decoded_length);
            if (bad) error_count++;
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int         random_items;
      int         count;
      result_type typed_res;
      random_items = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         typed_res = result_type'{decoded_length: directed_rows[i].exp_len,
                                  escape_error:   directed_rows[i].exp_bad,
                                  text_done:      directed_rows[i].exp_done,
                                  byte_valid:     directed_rows[i].exp_valid,
                                  decoded_byte:   directed_rows[i].exp_byte};
         send_request(item_type'{last_byte: directed_rows[i].last_byte,
                                 text_byte: directed_rows[i].text_byte},
                      directed_rows[i].typed, typed_res);
      end

      // hold off until the decoder has drained
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);

      // random texts
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) begin
            tx_gaps   = 1'b0;
            rx_stalls = 1'b0;
         end else begin
            tx_gaps   = ($urandom_range(0, 4) != 0);
            rx_stalls = ($urandom_range(0, 4) != 0);
         end
         build_random_text();
         count = text_q.size();
         while (text_q.size() != 0) send_request(text_q.pop_front(), 1'b0, '0);
         random_items += count;
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
